### hdl/moc_pkg.sv
package moc_pkg;

  localparam int NUM_CPUS    = 4;
  localparam int ROUNDS      = 32;
  localparam int EXTRA_MAGS  = 8;
  localparam int HANDLE_BITS = 48;

  localparam int MAG_TOTAL = 2 * NUM_CPUS + EXTRA_MAGS;
  localparam int MAG_W     = $clog2(MAG_TOTAL);
  localparam int CNT_W     = $clog2(ROUNDS + 1);
  localparam int IDX_W     = $clog2(ROUNDS);
  localparam int TOP_W     = $clog2(MAG_TOTAL + 1);
  localparam int CPU_IW    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int ADDR_W    = $clog2(MAG_TOTAL * ROUNDS);

  localparam int OP_W     = 1;
  localparam int CPU_W    = 2;
  localparam int STATUS_W = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_CACHE_ALLOC = 2'd0,
    ST_CACHE_FREE  = 2'd1,
    ST_BACK_ALLOC  = 2'd2,
    ST_BACK_FREE   = 2'd3
  } status_t;

  typedef struct packed {
    logic [MAG_W-1:0] id;
    logic [CNT_W-1:0] cnt;
  } mag_t;

  typedef struct packed {
    logic                   we;
    logic                   re;
    logic [ADDR_W-1:0]      addr;
    logic [HANDLE_BITS-1:0] wdata;
  } mem_req_t;

endpackage

### hdl/moc_req_if.sv
interface moc_req_if;
  import moc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        op;
  logic [CPU_W-1:0]       cpu;
  logic [HANDLE_BITS-1:0] obj;

  modport source (output valid, output op, output cpu, output obj, input ready);
  modport sink (input valid, input op, input cpu, input obj, output ready);
endinterface

### hdl/moc_rsp_if.sv
interface moc_rsp_if;
  import moc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [HANDLE_BITS-1:0] handle;
  logic [STATUS_W-1:0]    status;

  modport source (output valid, output handle, output status, input ready);
  modport sink (input valid, input handle, input status, output ready);
endinterface

### hdl/moc_cfg_if.sv
interface moc_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/moc_round_ram.sv
module moc_round_ram
  import moc_pkg::*;
(
  input  logic                   clk,
  input  mem_req_t               req,
  output logic [HANDLE_BITS-1:0] rd_data
);

  logic [HANDLE_BITS-1:0] mem [MAG_TOTAL*ROUNDS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

### hdl/moc_ctrl.sv
module moc_ctrl
  import moc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  logic                   enabled,
  input  logic [OP_W-1:0]        op,
  input  logic [CPU_W-1:0]       cpu,
  input  logic [HANDLE_BITS-1:0] obj,
  output status_t                status,
  output mem_req_t               mem_req
);

  mag_t             prim [NUM_CPUS];
  mag_t             sec [NUM_CPUS];
  mag_t             full_stack [MAG_TOTAL];
  mag_t             empty_stack [MAG_TOTAL];
  logic [TOP_W-1:0] full_top;
  logic [TOP_W-1:0] empty_top;

  logic              usable;
  logic [CPU_IW-1:0] ci;
  mag_t              p;
  mag_t              s;
  mag_t              pf;
  mag_t              prim_next;
  logic              hit;
  logic              swap;
  logic              dep;
  logic [IDX_W-1:0]  idx;
  logic [MAG_W-1:0]  full_pop;
  logic [MAG_W-1:0]  empty_pop;

  assign usable    = enabled && (32'(cpu) < NUM_CPUS);
  assign ci        = CPU_IW'(cpu);
  assign p         = prim[ci];
  assign s         = sec[ci];
  assign full_pop  = MAG_W'(full_top - 1'b1);
  assign empty_pop = MAG_W'(empty_top - 1'b1);

  always_comb begin
    hit  = 1'b0;
    swap = 1'b0;
    dep  = 1'b0;
    pf   = p;
    if (usable) begin
      if (op == OP_ALLOC) begin
        priority if (p.cnt != '0) begin
          hit = 1'b1;
        end else if (s.cnt == CNT_W'(ROUNDS)) begin
          swap = 1'b1;
          pf   = s;
          hit  = 1'b1;
        end else if (full_top != '0 && full_top <= TOP_W'(MAG_TOTAL)
                     && empty_top < TOP_W'(MAG_TOTAL)) begin
          dep = 1'b1;
          pf  = full_stack[full_pop];
          hit = (pf.cnt != '0) && (pf.cnt <= CNT_W'(ROUNDS));
        end else begin
          hit = 1'b0;
        end
      end else begin
        priority if (p.cnt < CNT_W'(ROUNDS)) begin
          hit = 1'b1;
        end else if (s.cnt == '0) begin
          swap = 1'b1;
          pf   = s;
          hit  = 1'b1;
        end else if (empty_top != '0 && empty_top <= TOP_W'(MAG_TOTAL)
                     && full_top < TOP_W'(MAG_TOTAL)) begin
          dep = 1'b1;
          pf  = empty_stack[empty_pop];
          hit = pf.cnt < CNT_W'(ROUNDS);
        end else begin
          hit = 1'b0;
        end
      end
    end

    prim_next = pf;
    if (hit) begin
      prim_next.cnt = (op == OP_ALLOC) ? pf.cnt - 1'b1 : pf.cnt + 1'b1;
    end

    idx = (op == OP_ALLOC) ? IDX_W'(pf.cnt - 1'b1) : IDX_W'(pf.cnt);

    mem_req.we    = go && hit && (op == OP_FREE);
    mem_req.re    = go && hit && (op == OP_ALLOC);
    mem_req.addr  = ADDR_W'(pf.id) * ADDR_W'(ROUNDS) + ADDR_W'(idx);
    mem_req.wdata = obj;

    if (op == OP_ALLOC) begin
      status = hit ? ST_CACHE_ALLOC : ST_BACK_ALLOC;
    end else begin
      status = hit ? ST_CACHE_FREE : ST_BACK_FREE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CPUS; i++) begin
        prim[i] <= '{id: MAG_W'(2 * i), cnt: '0};
        sec[i]  <= '{id: MAG_W'(2 * i + 1), cnt: '0};
      end
      for (int i = 0; i < MAG_TOTAL; i++) begin
        if (i < EXTRA_MAGS) begin
          empty_stack[i] <= '{id: MAG_W'(2 * NUM_CPUS + i), cnt: '0};
        end else begin
          empty_stack[i] <= '0;
        end
      end
      full_top  <= '0;
      empty_top <= TOP_W'(EXTRA_MAGS);
    end else if (go) begin
      if (swap || dep || hit) begin
        prim[ci] <= prim_next;
      end
      if (swap || dep) begin
        sec[ci] <= p;
      end
      if (dep && op == OP_ALLOC) begin
        empty_stack[MAG_W'(empty_top)] <= s;
        empty_top <= empty_top + 1'b1;
        full_top  <= full_top - 1'b1;
      end
      if (dep && op == OP_FREE) begin
        empty_top <= empty_top - 1'b1;
        full_top  <= full_top + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && dep && op == OP_FREE) begin
      full_stack[MAG_W'(full_top)] <= s;
    end
  end

endmodule

### hdl/magazine_object_cache_top.sv
// channel  role    signals
// req      sink    valid ready op cpu obj
// rsp      source  valid ready handle status
// cfg      sink    valid ready data (cache enable, always ready)
//
// One transaction per cycle while rsp is ready; req is registered, then rsp.
// The magazine decision and the round RAM access share the cycle between
// the request register and the response register; the RAM read is registered.
// Synchronous active-high reset; all magazine state is ready right after reset.
// A stalled rsp holds the response and backs up into the request register.
module magazine_object_cache_top
  import moc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  moc_req_if.sink   req,
  moc_rsp_if.source rsp,
  moc_cfg_if.sink   cfg
);

  logic                   enabled;
  logic                   in_valid;
  logic [OP_W-1:0]        in_op;
  logic [CPU_W-1:0]       in_cpu;
  logic [HANDLE_BITS-1:0] in_obj;
  logic                   out_valid;
  status_t                out_status;
  logic                   advance;
  status_t                status;
  mem_req_t               mem_req;
  logic [HANDLE_BITS-1:0] rd_data;

  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b1;
    end else if (cfg.valid) begin
      enabled <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_op  <= req.op;
      in_cpu <= req.cpu;
      in_obj <= req.obj;
    end
  end

  moc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .go      (advance),
    .enabled (enabled),
    .op      (in_op),
    .cpu     (in_cpu),
    .obj     (in_obj),
    .status  (status),
    .mem_req (mem_req)
  );

  moc_round_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status <= status;
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.handle = (out_status == ST_CACHE_ALLOC) ? rd_data : '0;

`ifndef SYNTHESIS
  a_read_gives_hit: assert property (@(posedge clk) disable iff (rst)
    mem_req.re |=> out_valid && out_status == ST_CACHE_ALLOC)
    else $error("round read without cache allocate response");

  a_disabled_backend: assert property (@(posedge clk) disable iff (rst)
    advance && !enabled |=> out_status == ST_BACK_ALLOC || out_status == ST_BACK_FREE)
    else $error("disabled cache answered from magazines");

  a_free_status: assert property (@(posedge clk) disable iff (rst)
    advance && in_op == OP_FREE
      |=> out_status == ST_CACHE_FREE || out_status == ST_BACK_FREE)
    else $error("free answered with allocate status");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_obj) && $stable(in_cpu))
    else $error("stalled request register changed");
`endif

endmodule

### dv/moc_reply_checker.sv
module moc_reply_checker
  import moc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  input  logic                   req_ready,
  input  logic [OP_W-1:0]        req_op,
  input  logic [CPU_W-1:0]       req_cpu,
  input  logic [HANDLE_BITS-1:0] req_obj,
  input  logic                   rsp_valid,
  input  logic                   rsp_ready,
  input  logic [HANDLE_BITS-1:0] rsp_handle,
  input  logic [STATUS_W-1:0]    rsp_status,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic                   cfg_data,
  output int                     fail_count,
  output int                     outstanding,
  output int                     status_hits [4]
);

  typedef struct packed {
    logic [HANDLE_BITS-1:0] handle;
    status_t                status;
  } reply_t;

  logic [HANDLE_BITS-1:0] mag_rounds [MAG_TOTAL][ROUNDS];
  int                     mag_fill [MAG_TOTAL];
  int                     cpu_primary [NUM_CPUS];
  int                     cpu_spare [NUM_CPUS];
  int                     full_depot [MAG_TOTAL];
  int                     empty_depot [MAG_TOTAL];
  int                     full_depth;
  int                     empty_depth;
  bit                     cache_on;

  reply_t pending_replies [$];
  reply_t oldest;

  function automatic void clear_magazines();
    for (int m = 0; m < MAG_TOTAL; m++) begin
      mag_fill[m]    = 0;
      full_depot[m]  = 0;
      empty_depot[m] = 0;
      for (int r = 0; r < ROUNDS; r++) begin
        mag_rounds[m][r] = '0;
      end
    end
    for (int c = 0; c < NUM_CPUS; c++) begin
      cpu_primary[c] = 2 * c;
      cpu_spare[c]   = 2 * c + 1;
    end
    for (int e = 0; e < EXTRA_MAGS; e++) begin
      empty_depot[e] = 2 * NUM_CPUS + e;
    end
    full_depth  = 0;
    empty_depth = EXTRA_MAGS;
    cache_on    = 1'b1;
  endfunction

  function automatic bit pop_round(input int c, output logic [HANDLE_BITS-1:0] h);
    int p;
    int s;
    p = cpu_primary[c];
    s = cpu_spare[c];
    h = '0;
    if (mag_fill[p] == 0) begin
      if (mag_fill[s] == ROUNDS) begin
        cpu_primary[c] = s;
        cpu_spare[c]   = p;
      end else if (full_depth > 0 && empty_depth < MAG_TOTAL) begin
        empty_depot[empty_depth] = s;
        empty_depth++;
        cpu_spare[c] = p;
        full_depth--;
        cpu_primary[c] = full_depot[full_depth];
      end else begin
        return 1'b0;
      end
      p = cpu_primary[c];
      if (mag_fill[p] == 0 || mag_fill[p] > ROUNDS) return 1'b0;
    end
    mag_fill[p]--;
    h = mag_rounds[p][mag_fill[p]];
    return 1'b1;
  endfunction

  function automatic bit push_round(input int c, input logic [HANDLE_BITS-1:0] h);
    int p;
    int s;
    p = cpu_primary[c];
    s = cpu_spare[c];
    if (mag_fill[p] >= ROUNDS) begin
      if (mag_fill[s] == 0) begin
        cpu_primary[c] = s;
        cpu_spare[c]   = p;
      end else if (empty_depth > 0 && full_depth < MAG_TOTAL) begin
        full_depot[full_depth] = s;
        full_depth++;
        cpu_spare[c] = p;
        empty_depth--;
        cpu_primary[c] = empty_depot[empty_depth];
      end else begin
        return 1'b0;
      end
      p = cpu_primary[c];
      if (mag_fill[p] >= ROUNDS) return 1'b0;
    end
    mag_rounds[p][mag_fill[p]] = h;
    mag_fill[p]++;
    return 1'b1;
  endfunction

  function automatic reply_t predict_reply(input logic [OP_W-1:0] op,
                                           input logic [CPU_W-1:0] cpu,
                                           input logic [HANDLE_BITS-1:0] obj);
    reply_t r;
    bit     usable;
    r.handle = '0;
    usable   = cache_on && (int'(cpu) < NUM_CPUS);
    if (op == OP_ALLOC) begin
      if (usable && pop_round(int'(cpu), r.handle)) begin
        r.status = ST_CACHE_ALLOC;
      end else begin
        r.handle = '0;
        r.status = ST_BACK_ALLOC;
      end
    end else begin
      if (usable && push_round(int'(cpu), obj)) r.status = ST_CACHE_FREE;
      else r.status = ST_BACK_FREE;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_magazines();
      pending_replies.delete();
    end else begin
      if (cfg_valid && cfg_ready) cache_on = cfg_data;
      if (rsp_valid && rsp_ready) begin
        if (!$isunknown(rsp_status)) status_hits[rsp_status]++;
        if (pending_replies.size() == 0) begin
          if (fail_count < 10) begin
            $display("unexpected transaction: handle %h status %0d", rsp_handle, rsp_status);
          end
          fail_count++;
        end else begin
          oldest = pending_replies.pop_front();
          if (rsp_handle !== oldest.handle || rsp_status !== oldest.status) begin
            if (fail_count < 10) begin
              $display("mismatch: expected handle %h status %0d, got handle %h status %0d",
                       oldest.handle, oldest.status, rsp_handle, rsp_status);
            end
            fail_count++;
          end
        end
      end
      if (req_valid && req_ready) begin
        pending_replies.push_back(predict_reply(req_op, req_cpu, req_obj));
      end
    end
    outstanding = pending_replies.size();
  end

endmodule

### dv/magazine_object_cache_top_tb.sv
module magazine_object_cache_top_tb;
  import moc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst;

  moc_req_if req_ch ();
  moc_rsp_if rsp_ch ();
  moc_cfg_if cfg_ch ();

  int fail_count;
  int outstanding;
  int status_hits [4];

  bit quiet;
  int hold_asks;
  int sent_count;
  int cfg_writes;
  int cycles;

  magazine_object_cache_top u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  moc_reply_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_ch.valid),
    .req_ready   (req_ch.ready),
    .req_op      (req_ch.op),
    .req_cpu     (req_ch.cpu),
    .req_obj     (req_ch.obj),
    .rsp_valid   (rsp_ch.valid),
    .rsp_ready   (rsp_ch.ready),
    .rsp_handle  (rsp_ch.handle),
    .rsp_status  (rsp_ch.status),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_data    (cfg_ch.data),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .status_hits (status_hits)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int hold_left;
    int holds_seen;
    hold_left      = 0;
    holds_seen     = 0;
    rsp_ch.ready   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != holds_seen) begin
        holds_seen = hold_asks;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(99) < 17) begin
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [HANDLE_BITS-1:0] random_obj();
    logic [63:0] wide;
    wide = {$urandom(), $urandom()};
    return wide[HANDLE_BITS-1:0];
  endfunction

  task automatic send_req(input logic [OP_W-1:0] op, input logic [CPU_W-1:0] cpu,
                          input logic [HANDLE_BITS-1:0] obj);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 17) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.cpu   <= cpu;
    req_ch.obj   <= obj;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_random();
    send_req(OP_W'($urandom_range(1, 0)), CPU_W'($urandom_range(3, 0)), random_obj());
  endtask

  task automatic drain_replies();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_enable(input logic value);
    drain_replies();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.op    = OP_ALLOC;
    req_ch.cpu   = '0;
    req_ch.obj   = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = 1'b0;
    quiet        = 1'b0;
    hold_asks    = 0;
    sent_count   = 0;
    cfg_writes   = 0;
    rst          = 1'b1;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    send_req(OP_ALLOC, 2'd0, '0);
    send_req(OP_FREE, 2'd3, '1);
    send_req(OP_FREE, 2'd2, '0);
    send_req(OP_FREE, 2'd1, {(HANDLE_BITS/2){2'b01}});
    send_req(OP_FREE, 2'd1, {(HANDLE_BITS/2){2'b10}});
    send_req(OP_ALLOC, 2'd3, random_obj());
    send_req(OP_ALLOC, 2'd2, '1);
    send_req(OP_ALLOC, 2'd1, '0);
    send_req(OP_ALLOC, 2'd1, '0);
    send_req(OP_ALLOC, 2'd1, '0);
    write_enable(1'b0);
    send_req(OP_FREE, 2'd0, random_obj());
    send_req(OP_ALLOC, 2'd1, '0);
    send_req(OP_FREE, 2'd3, '1);
    write_enable(1'b1);

    // flood cpu 0 with frees to walk the empty depot down to the backend path
    for (int i = 0; i < 360; i++) begin
      quiet = (i >= 120 && i < 220);
      if ($urandom_range(99) < 5) send_random();
      else send_req(OP_FREE, 2'd0, random_obj());
    end
    quiet = 1'b0;
    drain_replies();

    // allocate across cpus, pulling full magazines back out of the depot
    for (int i = 0; i < 140; i++) begin
      if (i == 20) hold_asks++;
      if ($urandom_range(99) < 5) send_random();
      else send_req(OP_ALLOC, CPU_W'($urandom_range(3, 0)), random_obj());
    end

    write_enable(1'b0);
    for (int i = 0; i < 25; i++) send_random();
    write_enable(1'b1);
    for (int i = 0; i < 25; i++) send_random();

    drain_replies();
    repeat (8) @(negedge clk);

    $display("summary: %0d requests over %0d enable writes", sent_count, cfg_writes);
    $display("summary: cache alloc %0d, cache free %0d, backend alloc %0d, backend free %0d",
             status_hits[ST_CACHE_ALLOC], status_hits[ST_CACHE_FREE],
             status_hits[ST_BACK_ALLOC], status_hits[ST_BACK_FREE]);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
